/* design/pps_pkg.sv */
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

    localparam int MAX_PROCS = 8;
    localparam int SLOT_W    = $clog2(MAX_PROCS);
    localparam int CNT_W     = 4;
    localparam int BUSY_W    = $clog2(MAX_PROCS + 1);
    localparam int ID_W      = 8;
    localparam int BURST_W   = 16;
    localparam int PRIO_W    = 8;
    localparam int HPRIO_W   = PRIO_W + 1;
    localparam int ARR_W     = 16;
    localparam int NOW_W     = 24;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    localparam logic [HPRIO_W-1:0] NO_PRIO = HPRIO_W'(256);
    localparam logic [NOW_W-1:0]   NOW_MAX = {NOW_W{1'b1}};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } sched_state_t;

    // Running best choice as it travels from one slot cell to the next.
    typedef struct packed {
        logic                have;
        logic [HPRIO_W-1:0]  prio;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     id;
        logic [BURST_W-1:0]  burst;
        logic [ARR_W-1:0]    arrival;
        logic [BURST_W-1:0]  rem;
        logic [BUSY_W-1:0]   busy_cnt;
    } cand_t;

    // Commands broadcast from the sequencer to every slot cell.
    typedef struct packed {
        logic                load;
        logic                dec;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     proc_id;
        logic [BURST_W-1:0]  burst;
        logic [PRIO_W-1:0]   prio;
        logic [ARR_W-1:0]    arrival;
        logic [NOW_W-1:0]    now;
    } cell_ctrl_t;

endpackage

/* design/pps_cell.sv */
// One process slot cell: holds the slot state and refines the passing candidate.
module pps_cell import pps_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SLOT_W-1:0] cell_idx,
    input  logic              in_use,
    input  cell_ctrl_t        ctrl,
    input  cand_t             cand_in,
    output cand_t             cand_out
);

    logic [ID_W-1:0]    id_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [PRIO_W-1:0]  prio_reg;
    logic [ARR_W-1:0]   arrival_reg;
    logic [BURST_W-1:0] rem_reg;
    logic [BURST_W-1:0] rem_next;
    cand_t              cand_reg;
    cand_t              cand_next;
    logic               busy;
    logic               eligible;

    assign busy     = in_use && (rem_reg != '0);
    assign eligible = busy && ({{(NOW_W-ARR_W){1'b0}}, arrival_reg} <= ctrl.now)
                      && ({1'b0, prio_reg} < cand_in.prio);

    always_comb begin
        cand_next = cand_in;
        if (in_use) begin
            if (cand_in.have && (cand_in.slot == cell_idx)) begin
                cand_next.id      = id_reg;
                cand_next.burst   = burst_reg;
                cand_next.arrival = arrival_reg;
                cand_next.rem     = rem_reg;
            end
            if (eligible) begin
                cand_next.have    = 1'b1;
                cand_next.prio    = {1'b0, prio_reg};
                cand_next.slot    = cell_idx;
                cand_next.id      = id_reg;
                cand_next.burst   = burst_reg;
                cand_next.arrival = arrival_reg;
                cand_next.rem     = rem_reg;
            end
            if (busy) begin
                cand_next.busy_cnt = cand_in.busy_cnt + BUSY_W'(1);
            end
        end
    end

    always_comb begin
        rem_next = rem_reg;
        if (ctrl.load && (ctrl.slot == cell_idx)) begin
            rem_next = ctrl.burst;
        end else if (ctrl.dec && (ctrl.slot == cell_idx)) begin
            rem_next = rem_reg - BURST_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
        if (ctrl.load && (ctrl.slot == cell_idx)) begin
            id_reg      <= ctrl.proc_id;
            burst_reg   <= ctrl.burst;
            prio_reg    <= ctrl.prio;
            arrival_reg <= ctrl.arrival;
        end
    end

    assign cand_out = cand_reg;

endmodule

/* design/preemptive_priority_scheduler_unit.sv */
// Top level of the preemptive priority scheduler: sequencer, slot cell chain, result register.
//
// Channel   Dir  Handshake          Contents
// s_axis    in   s_tvalid/s_tready  one command: load a slot or advance one tick
// m_axis    out  m_tvalid/m_tready  one result per tick, none per load
// cfg       in   cfg_valid/cfg_ready number of slots in use
//
// A load is taken while idle. On a tick the candidate walks
// through the chain of slot cells, one cell per cycle, then the commit state commits it.
// The commit waits while the result register still holds an untaken result.
// Reset is synchronous and active low; no clearing pass is needed.
module preemptive_priority_scheduler_unit import pps_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // slot, proc_id, burst, prio, arrival, zero pad
    input  logic [0:0]           s_tuser,  // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // ran_id, finished_slot, wait_time, all_done, zero pad
    output logic [1:0]           m_tuser,  // idle, finished
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_W-1:0]     cfg_data
);

    sched_state_t        state_reg, state_next;
    logic [SLOT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]    pcount_reg;
    logic [NOW_W-1:0]    now_reg, now_next;
    logic [HPRIO_W-1:0]  held_reg, held_next;
    logic [SLOT_W-1:0]   cur_slot_reg, cur_slot_next;
    logic                cur_valid_reg, cur_valid_next;
    cand_t               seed_reg, seed_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]          m_tuser_reg, m_tuser_next;

    logic [SLOT_W-1:0]   in_slot;
    logic [ID_W-1:0]     in_id;
    logic [BURST_W-1:0]  in_burst;
    logic [PRIO_W-1:0]   in_prio;
    logic [ARR_W-1:0]    in_arrival;

    logic                in_fire;
    logic                load_fire;
    logic                tick_fire;
    logic                commit_fire;
    logic [MAX_PROCS-1:0] in_use;
    cand_t               chain [MAX_PROCS+1];
    cand_t               best;
    cell_ctrl_t          ctrl;
    logic [NOW_W-1:0]    now_inc;
    logic [NOW_W-1:0]    sub;
    logic [NOW_W-1:0]    wait_val;
    logic                fin;
    logic                all_done;

    assign in_slot    = s_tdata[2:0];
    assign in_id      = s_tdata[10:3];
    assign in_burst   = s_tdata[26:11];
    assign in_prio    = s_tdata[34:27];
    assign in_arrival = s_tdata[50:35];

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_fire     = s_tvalid && s_tready;
    assign load_fire   = in_fire && (s_tuser[0] == CMD_LOAD);
    assign tick_fire   = in_fire && (s_tuser[0] == CMD_TICK);
    assign commit_fire = (state_reg == ST_COMMIT) && (!m_tvalid_reg || m_tready);
    assign cfg_ready   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg <= CNT_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            pcount_reg <= cfg_data;
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_PROCS; k++) begin : g_cell
            assign in_use[k] = ({1'b0, pcount_reg} > (CNT_W + 1)'(k));
            pps_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cell_idx (SLOT_W'(k)),
                .in_use   (in_use[k]),
                .ctrl     (ctrl),
                .cand_in  (chain[k]),
                .cand_out (chain[k+1])
            );
        end
    endgenerate

    assign chain[0] = seed_reg;
    assign best     = chain[MAX_PROCS];

    always_comb begin
        ctrl         = '0;
        ctrl.load    = load_fire;
        ctrl.dec     = commit_fire && best.have;
        ctrl.slot    = load_fire ? in_slot : best.slot;
        ctrl.proc_id = in_id;
        ctrl.burst   = in_burst;
        ctrl.prio    = in_prio;
        ctrl.arrival = in_arrival;
        ctrl.now     = now_reg;
    end

    always_comb begin
        seed_next          = '0;
        seed_next.have     = cur_valid_reg && in_use[cur_slot_reg];
        seed_next.prio     = seed_next.have ? held_reg : NO_PRIO;
        seed_next.slot     = cur_slot_reg;
    end

    assign now_inc  = (now_reg == NOW_MAX) ? now_reg : now_reg + NOW_W'(1);
    assign sub      = NOW_W'({1'b0, best.burst} + {1'b0, best.arrival});
    assign wait_val = (now_inc > sub) ? (now_inc - sub) : '0;
    assign fin      = best.have && (best.rem == BURST_W'(1));
    assign all_done = (best.busy_cnt == '0) ||
                      (best.have && fin && (best.busy_cnt == BUSY_W'(1)));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (tick_fire) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_cnt_reg == SLOT_W'(MAX_PROCS - 1)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (commit_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        scan_cnt_next  = scan_cnt_reg;
        now_next       = now_reg;
        held_next      = held_reg;
        cur_slot_next  = cur_slot_reg;
        cur_valid_next = cur_valid_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        case (state_reg)
            ST_IDLE: begin
                scan_cnt_next = '0;
                if (load_fire && cur_valid_reg && (cur_slot_reg == in_slot)) begin
                    cur_valid_next = 1'b0;
                    held_next      = NO_PRIO;
                end
            end
            ST_SCAN: begin
                scan_cnt_next = scan_cnt_reg + SLOT_W'(1);
            end
            ST_COMMIT: begin
                if (commit_fire) begin
                    now_next      = now_inc;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tuser_next  = '0;
                    m_tdata_next[35] = all_done;
                    if (!best.have) begin
                        m_tuser_next[0] = 1'b1;
                        cur_valid_next  = 1'b0;
                        held_next       = NO_PRIO;
                    end else begin
                        m_tdata_next[7:0] = best.id;
                        if (fin) begin
                            m_tuser_next[1]     = 1'b1;
                            m_tdata_next[10:8]  = best.slot;
                            m_tdata_next[34:11] = wait_val;
                            cur_valid_next      = 1'b0;
                            held_next           = NO_PRIO;
                        end else begin
                            cur_valid_next = 1'b1;
                            cur_slot_next  = best.slot;
                            held_next      = best.prio;
                        end
                    end
                end
            end
            default: begin
                scan_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            now_reg       <= '0;
            held_reg      <= NO_PRIO;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            now_reg       <= now_next;
            held_reg      <= held_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_fire) begin
            seed_reg <= seed_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* design/pps_checker.sv */
// Port-level checker for the preemptive priority scheduler, bound to the top level.
module pps_checker import pps_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [0:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[7:0] == '0) && !m_tuser[1])
        else $error("idle result carries a process");

    a_fin_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> (m_tdata[34:8] == '0))
        else $error("completion fields set without completion");

    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == CMD_TICK) |=> !s_tready)
        else $error("new transaction taken while a tick is in progress");

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* sim/pps_result_checker.sv */
// Watches the scheduler's channels, predicts every tick result and compares it with the block.
module pps_result_checker import pps_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // slot, proc_id, burst, prio, arrival, zero pad
    input  logic [0:0]           s_tuser,  // cmd
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,  // ran_id, finished_slot, wait_time, all_done, zero pad
    input  logic [1:0]           m_tuser,  // idle, finished
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CNT_W-1:0]     cfg_data,
    output int                   errors,
    output int                   waiting
);

    localparam int P_ID    = SLOT_W;
    localparam int P_BURST = P_ID + ID_W;
    localparam int P_PRIO  = P_BURST + BURST_W;
    localparam int P_ARR   = P_PRIO + PRIO_W;
    localparam int R_SLOT  = ID_W;
    localparam int R_WAIT  = R_SLOT + SLOT_W;
    localparam int R_DONE  = R_WAIT + NOW_W;

    typedef struct packed {
        logic [ID_W-1:0]   ran_id;
        logic              idle;
        logic              finished;
        logic [SLOT_W-1:0] fin_slot;
        logic [NOW_W-1:0]  wait_t;
        logic              all_done;
    } tick_result_t;

    logic [CNT_W-1:0]   proc_count;
    logic [ID_W-1:0]    id_tab    [MAX_PROCS];
    logic [BURST_W-1:0] burst_tab [MAX_PROCS];
    logic [BURST_W-1:0] rem_tab   [MAX_PROCS];
    logic [PRIO_W-1:0]  pri_tab   [MAX_PROCS];
    logic [ARR_W-1:0]   arr_tab   [MAX_PROCS];
    logic [NOW_W-1:0]   now_t;
    logic [HPRIO_W-1:0] run_prio;
    logic [SLOT_W-1:0]  run_slot;
    logic               run_valid;

    tick_result_t tick_results_q[$];
    int           result_no;

    task automatic run_tick(output tick_result_t r);
        int                 lim;
        int                 done_n;
        logic               have;
        logic [SLOT_W-1:0]  pick;
        logic [HPRIO_W-1:0] best;
        logic [BURST_W:0]   sub;
        lim  = (int'(proc_count) > MAX_PROCS) ? MAX_PROCS : int'(proc_count);
        have = 1'b0;
        pick = '0;
        best = NO_PRIO;
        if (run_valid && int'(run_slot) < lim && rem_tab[run_slot] != 0) begin
            have = 1'b1;
            pick = run_slot;
            best = run_prio;
        end
        for (int j = 0; j < lim; j++) begin
            if (NOW_W'(arr_tab[j]) <= now_t && rem_tab[j] != 0 &&
                HPRIO_W'(pri_tab[j]) < best) begin
                have = 1'b1;
                pick = SLOT_W'(j);
                best = HPRIO_W'(pri_tab[j]);
            end
        end
        if (now_t != NOW_MAX)
            now_t = now_t + 1'b1;
        r = '0;
        if (!have) begin
            r.idle    = 1'b1;
            run_valid = 1'b0;
            run_prio  = NO_PRIO;
        end else begin
            r.ran_id = id_tab[pick];
            rem_tab[pick] = rem_tab[pick] - 1'b1;
            if (rem_tab[pick] == 0) begin
                sub = {1'b0, burst_tab[pick]} + {1'b0, arr_tab[pick]};
                r.finished = 1'b1;
                r.fin_slot = pick;
                r.wait_t   = (now_t > NOW_W'(sub)) ? now_t - NOW_W'(sub) : '0;
                run_valid  = 1'b0;
                run_prio   = NO_PRIO;
            end else begin
                run_valid = 1'b1;
                run_slot  = pick;
                run_prio  = best;
            end
        end
        done_n = 0;
        for (int j = 0; j < lim; j++)
            if (rem_tab[j] == 0)
                done_n++;
        r.all_done = (done_n == lim);
    endtask

    always @(posedge aclk) begin : watch
        tick_result_t      want;
        tick_result_t      got;
        logic [SLOT_W-1:0] s;
        if (!aresetn) begin
            proc_count = CNT_W'(1);
            for (int j = 0; j < MAX_PROCS; j++) begin
                id_tab[j]    = '0;
                burst_tab[j] = '0;
                rem_tab[j]   = '0;
                pri_tab[j]   = '0;
                arr_tab[j]   = '0;
            end
            now_t     = '0;
            run_prio  = NO_PRIO;
            run_slot  = '0;
            run_valid = 1'b0;
            result_no = 0;
            tick_results_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.ran_id   = m_tdata[ID_W-1:0];
                got.idle     = m_tuser[0];
                got.finished = m_tuser[1];
                got.fin_slot = m_tdata[R_SLOT +: SLOT_W];
                got.wait_t   = m_tdata[R_WAIT +: NOW_W];
                got.all_done = m_tdata[R_DONE];
                if (tick_results_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d arrived with no tick waiting for it", result_no);
                end else begin
                    want = tick_results_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("result %0d mismatch", result_no);
                            $display("  want id=%0d idle=%0b fin=%0b slot=%0d wait=%0d done=%0b",
                                     want.ran_id, want.idle, want.finished, want.fin_slot,
                                     want.wait_t, want.all_done);
                            $display("  got  id=%0d idle=%0b fin=%0b slot=%0d wait=%0d done=%0b",
                                     got.ran_id, got.idle, got.finished, got.fin_slot,
                                     got.wait_t, got.all_done);
                        end
                    end
                end
                result_no++;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == CMD_TICK) begin
                    run_tick(want);
                    tick_results_q = {tick_results_q, want};
                end else begin
                    s = s_tdata[SLOT_W-1:0];
                    id_tab[s]    = s_tdata[P_ID +: ID_W];
                    burst_tab[s] = s_tdata[P_BURST +: BURST_W];
                    rem_tab[s]   = s_tdata[P_BURST +: BURST_W];
                    pri_tab[s]   = s_tdata[P_PRIO +: PRIO_W];
                    arr_tab[s]   = s_tdata[P_ARR +: ARR_W];
                    if (run_valid && run_slot == s) begin
                        run_valid = 1'b0;
                        run_prio  = NO_PRIO;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                proc_count = cfg_data;
        end
        waiting = tick_results_q.size();
    end

endmodule

/* sim/preemptive_priority_scheduler_unit_test.sv */
// Testbench top of the preemptive priority scheduler: clock, reset, stimulus and verdict.
module preemptive_priority_scheduler_unit_test;
    import pps_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data;
    int                   errors;
    int                   waiting;
    bit                   calm;
    int                   ticks_sent;

    preemptive_priority_scheduler_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pps_result_checker chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .waiting   (waiting)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    initial begin
        #2000000;
        $display("FAIL preemptive_priority_scheduler_unit");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [SLOT_W-1:0] slot,
                             input logic [ID_W-1:0] pid, input logic [BURST_W-1:0] burst,
                             input logic [PRIO_W-1:0] prio, input logic [ARR_W-1:0] arr);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({arr, prio, burst, pid, slot});
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_TICK)
            ticks_sent++;
    endtask

    task automatic send_tick;
        send_item(CMD_TICK, SLOT_W'($urandom), ID_W'($urandom), BURST_W'($urandom),
                  PRIO_W'($urandom), ARR_W'($urandom));
    endtask

    task automatic load_proc(input logic [SLOT_W-1:0] slot);
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [ARR_W-1:0]   arr;
        prio = ($urandom_range(0, 4) == 0) ? PRIO_W'($urandom_range(0, 255))
                                           : PRIO_W'($urandom_range(0, 15));
        if ($urandom_range(0, 39) == 0) begin
            burst = BURST_W'($urandom);
            prio  = 8'hFF;
        end else if ($urandom_range(0, 14) == 0) begin
            burst = '0;
        end else begin
            burst = BURST_W'($urandom_range(1, 10));
        end
        arr = ($urandom_range(0, 19) == 0) ? ARR_W'($urandom)
                                           : ARR_W'(ticks_sent + $urandom_range(0, 25));
        send_item(CMD_LOAD, slot, ID_W'($urandom), burst, prio, arr);
    endtask

    task automatic settle;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (waiting != 0) @(negedge aclk);
        repeat (24) @(negedge aclk);
    endtask

    task automatic set_count(input logic [CNT_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : receiver
        int gap;
        int taken;
        m_tready = 1'b0;
        taken = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 9);
            if (taken == 250 || taken == 1000)
                gap = 300;
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    initial begin : stimulus
        int cnt;
        int r;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        calm       = 1'b0;
        ticks_sent = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Every slot is loaded before the first tick so that no table entry is read unset.
        send_item(CMD_LOAD, 3'd0, 8'hFF, 16'd3,     8'd5,   16'd0);
        send_item(CMD_LOAD, 3'd1, 8'h01, 16'd2,     8'd5,   16'd0);
        send_item(CMD_LOAD, 3'd2, 8'h02, 16'd0,     8'd0,   16'd0);
        send_item(CMD_LOAD, 3'd3, 8'h03, 16'd2,     8'd1,   16'd2);
        send_item(CMD_LOAD, 3'd4, 8'h04, 16'd1,     8'd255, 16'd0);
        send_item(CMD_LOAD, 3'd5, 8'h05, 16'd1,     8'd0,   16'd40);
        send_item(CMD_LOAD, 3'd6, 8'h06, 16'd1,     8'd7,   16'd0);
        send_item(CMD_LOAD, 3'd7, 8'h00, 16'hFFFF,  8'd255, 16'hFFFF);
        send_tick();
        send_tick();
        set_count(4'd0);
        send_tick();
        send_tick();
        set_count(4'd15);
        repeat (3) send_tick();
        send_item(CMD_LOAD, 3'd0, 8'hFF, 16'd2, 8'd5, 16'd0);
        repeat (4) send_tick();
        set_count(4'd8);
        repeat (3) send_tick();

        for (int ph = 0; ph < 17; ph++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                cnt = 0;
            else if (r == 1)
                cnt = $urandom_range(9, 15);
            else if (r == 2)
                cnt = 8;
            else
                cnt = $urandom_range(1, 8);
            set_count(CNT_W'(cnt));
            calm = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < MAX_PROCS; j++)
                load_proc(SLOT_W'(j));
            for (int k = 0; k < 92; k++) begin
                if ($urandom_range(0, 4) != 0)
                    send_tick();
                else if ($urandom_range(0, 9) == 0)
                    send_item(CMD_LOAD, SLOT_W'($urandom), ID_W'($urandom),
                              BURST_W'($urandom), PRIO_W'($urandom), ARR_W'($urandom));
                else
                    load_proc(SLOT_W'($urandom));
            end
        end

        calm = 1'b0;
        settle();
        if (errors == 0 && waiting == 0)
            $display("PASS preemptive_priority_scheduler_unit");
        else
            $display("FAIL preemptive_priority_scheduler_unit");
        $finish;
    end

endmodule
